// File: hw/rtl/aht_pkg.sv
// Shared constants and types for the averaged hysteresis thermostat.
// No dependencies; imported by aht_window, the top level and the bench files.
package aht_pkg;

    // Averaging window and derived widths
    localparam int WINDOW_SIZE = 20;
    localparam int WIDX_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int TEMP_W      = 16;
    localparam int BAND_W      = 12;
    localparam int CFG_W       = 16;
    // |sample| <= 2^15, so the sum needs clog2(N) + 16 magnitude bits plus sign
    localparam int SUM_W       = $clog2(WINDOW_SIZE) + TEMP_W + 1;
    // thresholds N*(max - band) reach below -N*2^15, one more bit
    localparam int TH_W        = SUM_W + 1;
    localparam int OUT_SUM_W   = 21;

    // Stream payload layout
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd5632;
    localparam logic [BAND_W-1:0]        BAND_RST     = 12'd512;

    // Register indexes
    typedef enum logic {
        REG_MAX_TEMP = 1'b0,
        REG_HYST     = 1'b1
    } t_reg_idx;

    // Commands
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_ON    = 3'd1,
        CMD_OFF   = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_FORCE = 3'd4
    } t_cmd;

endpackage

// File: hw/rtl/aht_window.sv
// Sample ring and running sum for the thermostat averaging window.
// Depends on aht_pkg.
module aht_window (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic signed [aht_pkg::TEMP_W-1:0]    i_sample,
    output logic signed [aht_pkg::SUM_W-1:0]     o_sum
);
    import aht_pkg::*;

    logic signed [TEMP_W-1:0] r_ring [WINDOW_SIZE];
    logic [WIDX_W-1:0]        r_widx;
    logic [WIDX_W-1:0]        n_widx;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [TEMP_W-1:0] oldest;

    // replace the oldest entry and adjust the sum by the difference
    assign oldest = r_ring[r_widx];
    assign n_sum  = r_sum - SUM_W'(oldest) + SUM_W'(i_sample);
    assign n_widx = (r_widx == WIDX_W'(WINDOW_SIZE - 1)) ? '0 : r_widx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_SIZE; k++) begin
                r_ring[k] <= '0;
            end
            r_widx <= '0;
            r_sum  <= '0;
        end else if (i_wr_en) begin
            r_ring[r_widx] <= i_sample;
            r_widx         <= n_widx;
            r_sum          <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: hw/rtl/averaged_hysteresis_thermostat.sv
// Averaged hysteresis thermostat: stream in, command stage, result register.
// Depends on aht_pkg and aht_window.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata, tuser
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata
//  cfg       in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the result side is not stalled; the
// window and the command stage register update when a request is accepted,
// then the command decision lands in the result register, which offers it.
// The running sum register is updated once per accepted request with sample_valid.
// Reset clears the 20-entry ring, sum, flags and pipeline valid bits.
// A stalled result holds both stages; the input stays ready while the
// command stage is empty or moving its request into the result register.
module averaged_hysteresis_thermostat (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: temp_sample[15:0], command[18:16], tens_count[20:19], zeros
    input  logic [aht_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: sample_valid
    input  logic                              s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: heating_on[0], element1_on[1], element2_on[2], hold_mode[3],
    //        average_sum[24:4], zeros
    output logic [aht_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [aht_pkg::CFG_W-1:0]         i_cfg_data
);
    import aht_pkg::*;

    localparam logic signed [TH_W-1:0] WIN_S  = TH_W'(WINDOW_SIZE);
    localparam logic signed [TH_W-1:0] THR_MAX_RST =
        TH_W'(WINDOW_SIZE * int'(MAX_TEMP_RST));
    localparam logic signed [TH_W-1:0] THR_LOW_RST =
        TH_W'(WINDOW_SIZE * (int'(MAX_TEMP_RST) - int'(BAND_RST)));

    // configuration and precomputed thresholds (N*max, N*(max-band))
    logic signed [TEMP_W-1:0] r_max_temp;
    logic [BAND_W-1:0]        r_band;
    logic signed [TH_W-1:0]   r_thr_max;
    logic signed [TH_W-1:0]   r_thr_low;
    logic signed [TH_W-1:0]   cfg_max_ext;
    logic signed [TH_W-1:0]   cfg_band_ext;
    logic signed [TH_W-1:0]   cur_max_ext;
    logic signed [TH_W-1:0]   cur_band_ext;

    assign cfg_max_ext  = TH_W'($signed(i_cfg_data[TEMP_W-1:0]));
    assign cfg_band_ext = TH_W'(i_cfg_data[BAND_W-1:0]);
    assign cur_max_ext  = TH_W'(r_max_temp);
    assign cur_band_ext = TH_W'(r_band);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_temp <= MAX_TEMP_RST;
            r_band     <= BAND_RST;
            r_thr_max  <= THR_MAX_RST;
            r_thr_low  <= THR_LOW_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MAX_TEMP: begin
                    r_max_temp <= $signed(i_cfg_data[TEMP_W-1:0]);
                    r_thr_max  <= WIN_S * cfg_max_ext;
                    r_thr_low  <= WIN_S * (cfg_max_ext - cur_band_ext);
                end
                REG_HYST: begin
                    r_band    <= i_cfg_data[BAND_W-1:0];
                    r_thr_low <= WIN_S * (cur_max_ext - cfg_band_ext);
                end
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic adv;
    logic s_accept;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // window update happens on accept of a request with sample_valid set
    logic signed [SUM_W-1:0] win_sum;

    aht_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (s_accept && s_axis_tuser),
        .i_sample ($signed(s_axis_tdata[TEMP_W-1:0])),
        .o_sum    (win_sum)
    );

    // command stage register
    t_cmd       r_s1_cmd;
    logic [1:0] r_s1_tens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_cmd  <= t_cmd'(s_axis_tdata[18:16]);
            r_s1_tens <= s_axis_tdata[20:19];
        end
    end

    // the sum register holds the post-update sum of the request in stage 1
    logic signed [TH_W-1:0] sum_ext;
    logic                   below_max;
    logic                   below_low;

    assign sum_ext   = TH_W'(win_sum);
    assign below_max = sum_ext < r_thr_max;
    assign below_low = sum_ext < r_thr_low;

    // flag update
    logic r_heat, r_rel1, r_rel2, r_hold;
    logic n_heat, n_rel1, n_rel2, n_hold;

    always_comb begin
        n_heat = r_heat;
        n_rel1 = r_rel1;
        n_rel2 = r_rel2;
        n_hold = r_hold;
        unique case (r_s1_cmd)
            CMD_ON: begin
                n_rel2 = 1'b1;
                if (below_max) begin
                    n_rel1 = 1'b1;
                    n_heat = 1'b1;
                end else begin
                    n_hold = 1'b1;
                end
            end
            CMD_OFF: begin
                n_heat = 1'b0;
                n_rel1 = 1'b0;
                n_rel2 = 1'b0;
                n_hold = 1'b0;
            end
            CMD_STOP: begin
                n_heat = 1'b0;
                n_rel1 = 1'b0;
                n_rel2 = 1'b0;
            end
            CMD_FORCE: begin
                if (r_s1_tens != 2'd0) begin
                    n_rel1 = 1'b1;
                end
                if (r_s1_tens[1]) begin
                    n_rel2 = 1'b1;
                end
                n_heat = 1'b1;
            end
            // regulate; unused codes behave the same
            default: begin
                if (r_heat && !below_max) begin
                    n_rel1 = 1'b0;
                    n_heat = 1'b0;
                    n_hold = 1'b1;
                end else if (r_hold && below_low) begin
                    n_rel1 = 1'b1;
                    n_heat = 1'b1;
                    n_hold = 1'b0;
                end
            end
        endcase
    end

    // result register: the flags themselves plus a copy of the sum
    logic [OUT_SUM_W-1:0] r_out_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_heat      <= 1'b0;
            r_rel1      <= 1'b0;
            r_rel2      <= 1'b0;
            r_hold      <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_heat <= n_heat;
                r_rel1 <= n_rel1;
                r_rel2 <= n_rel2;
                r_hold <= n_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_sum <= win_sum[OUT_SUM_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - OUT_SUM_W - 4){1'b0}},
                            r_out_sum, r_hold, r_rel2, r_rel1, r_heat};

    // checks
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> r_s1_valid)
        else $error("command stage lost a request while stalled");

    a_out_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (m_axis_tvalid == $past(r_s1_valid)))
        else $error("result valid does not follow the command stage");

    a_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && r_s1_cmd == CMD_OFF) |=>
        (!r_heat && !r_rel1 && !r_rel2 && !r_hold))
        else $error("device off left a flag set");

    a_on_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && r_s1_cmd == CMD_ON && below_max) |=>
        (r_heat && r_rel1 && r_rel2))
        else $error("device on below max did not start heating");

endmodule

// File: bench/thermostat_checker.sv
// Checker for the averaged hysteresis thermostat: watches the input, output and
// register write channels, predicts each status word and compares it.
// Depends on aht_pkg.
module thermostat_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // tdata: temp_sample[15:0], command[18:16], tens_count[20:19], zeros
    input  logic [aht_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: sample_valid
    input  logic                          i_s_tuser,
    // output stream
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: heating_on[0], element1_on[1], element2_on[2], hold_mode[3],
    //        average_sum[24:4], zeros
    input  logic [aht_pkg::M_TDATA_W-1:0] i_m_tdata,
    // register writes
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [aht_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_swing_count
);
    import aht_pkg::*;

    typedef struct packed {
        logic                 heating;
        logic                 elem1;
        logic                 elem2;
        logic                 hold;
        logic [OUT_SUM_W-1:0] sum;
    } t_status;

    // Predicted thermostat state
    logic signed [TEMP_W-1:0] ring [WINDOW_SIZE];
    int                       slot;
    longint                   sum_exact;
    logic                     heat, relay1, relay2, hold;
    logic signed [TEMP_W-1:0] max_temp;
    logic [BAND_W-1:0]        band;

    t_status status_due[$];
    int      fails;
    int      results;
    int      swings;

    // average < threshold, done on the sum without dividing
    function automatic logic avg_below(longint threshold);
        return sum_exact < longint'(WINDOW_SIZE) * threshold;
    endfunction

    // One tick: optional sample store, then the command
    function automatic t_status step_thermostat(logic sv, logic signed [TEMP_W-1:0] temp,
                                                logic [2:0] cmd, logic [1:0] tens);
        t_status st;
        if (sv) begin
            sum_exact = sum_exact - ring[slot] + temp;
            ring[slot] = temp;
            slot = (slot == WINDOW_SIZE - 1) ? 0 : slot + 1;
        end
        case (cmd)
            CMD_ON: begin
                relay2 = 1'b1;
                if (avg_below(longint'(max_temp))) begin
                    relay1 = 1'b1;
                    heat = 1'b1;
                end else begin
                    hold = 1'b1;
                end
            end
            CMD_OFF: begin
                heat = 1'b0;
                relay1 = 1'b0;
                relay2 = 1'b0;
                hold = 1'b0;
            end
            CMD_STOP: begin
                heat = 1'b0;
                relay1 = 1'b0;
                relay2 = 1'b0;
            end
            CMD_FORCE: begin
                if (tens >= 2'd1) relay1 = 1'b1;
                if (tens >= 2'd2) relay2 = 1'b1;
                heat = 1'b1;
            end
            // none and the unused codes regulate
            default: begin
                if (heat && !avg_below(longint'(max_temp))) begin
                    relay1 = 1'b0;
                    heat = 1'b0;
                    hold = 1'b1;
                    swings++;
                end else if (hold &&
                             avg_below(longint'(max_temp) - longint'(band))) begin
                    relay1 = 1'b1;
                    heat = 1'b1;
                    hold = 1'b0;
                    swings++;
                end
            end
        endcase
        st.heating = heat;
        st.elem1   = relay1;
        st.elem2   = relay2;
        st.hold    = hold;
        st.sum     = OUT_SUM_W'(sum_exact);
        return st;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_status due;
        if (!i_rst_n) begin
            foreach (ring[k]) ring[k] = '0;
            slot = 0;
            sum_exact = 0;
            heat = 1'b0;
            relay1 = 1'b0;
            relay2 = 1'b0;
            hold = 1'b0;
            max_temp = MAX_TEMP_RST;
            band = BAND_RST;
            status_due.delete();
        end else begin
            // register writes are to land only while the block is idle; the block does not enforce it
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_MAX_TEMP: max_temp = i_cfg_data;
                    REG_HYST:     band = i_cfg_data[BAND_W-1:0];
                    default:      ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                status_due.push_back(step_thermostat(i_s_tuser, i_s_tdata[15:0],
                                                     i_s_tdata[18:16], i_s_tdata[20:19]));
            if (i_m_tvalid && i_m_tready) begin
                results++;
                if (status_due.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, got %h",
                             $time, i_m_tdata);
                end else begin
                    due = status_due.pop_front();
                    check_field("heating_on", due.heating, i_m_tdata[0]);
                    check_field("element1_on", due.elem1, i_m_tdata[1]);
                    check_field("element2_on", due.elem2, i_m_tdata[2]);
                    check_field("hold_mode", due.hold, i_m_tdata[3]);
                    check_field("average_sum", int'($signed(due.sum)),
                                int'($signed(i_m_tdata[24:4])));
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= status_due.size();
        o_result_count <= results;
        o_swing_count  <= swings;
    end

endmodule

// File: bench/tb.sv
// Testbench top for averaged_hysteresis_thermostat: clock, reset, stimulus,
// register settings and verdict. Depends on aht_pkg and thermostat_checker.
module tb;
    import aht_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 1026;
    localparam int PHASES        = 8;
    localparam logic signed [TEMP_W-1:0] TEMP_LO = -16'sd10240;
    localparam logic signed [TEMP_W-1:0] TEMP_HI = 16'sd32000;
    // command codes with no function of their own
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int  fail_count, pending, result_count, swing_count;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  cfg_writes = 0;
    int  cur_max = 5632;
    int  cur_band = 512;
    bit  no_idle = 1'b0;

    averaged_hysteresis_thermostat uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    thermostat_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_swing_count  (swing_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic logic [TEMP_W-1:0] clamp_temp(int t);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return TEMP_W'(t);
    endfunction

    // Send one request; tvalid stays high afterwards unless the next one waits
    task automatic send_item(logic sv, logic [TEMP_W-1:0] temp, logic [2:0] cmd,
                             logic [1:0] tens);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= sv;
        s_tdata  <= {{(S_TDATA_W - 21){1'b0}}, tens, cmd, temp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Stop sending and wait until every result is back, plus a short pause
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_config(int max_t, int band_v);
        drain();
        write_reg(REG_MAX_TEMP, CFG_W'(max_t));
        write_reg(REG_HYST, CFG_W'(band_v));
        cur_max  = max_t;
        cur_band = band_v;
    endtask

    // A burst is either a heat-up / cool-down swing around the thresholds
    // or plain noise over every field value
    task automatic run_burst();
        int len, r, t;
        logic [2:0] cmd;
        len = $urandom_range(8, 24);
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1))
                send_item(1'b1, clamp_temp(cur_max - cur_band), CMD_ON, 2'd0);
            else
                send_item(1'b1, clamp_temp(cur_max), CMD_FORCE, 2'($urandom_range(0, 3)));
            for (int i = 0; i < len; i++) begin
                if (i < len / 2)
                    t = cur_max + int'($urandom_range(0, 4096));
                else
                    t = cur_max - cur_band - int'($urandom_range(0, 4096));
                r = $urandom_range(0, 19);
                cmd = (r < 16) ? CMD_NONE : (r == 16) ? CMD_ON : (r == 17) ? CMD_FORCE :
                      (r == 18) ? CMD_STOP : CMD_OFF;
                send_item($urandom_range(0, 9) != 0, clamp_temp(t), cmd,
                          2'($urandom_range(0, 3)));
            end
        end else begin
            for (int i = 0; i < len; i++)
                send_item(1'($urandom_range(0, 1)), TEMP_W'($urandom_range(0, 65535)),
                          3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        end
    endtask

    // Result side stalls a random number of cycles before each result
    initial begin
        int rx_wait;
        wait (rst_n);
        forever begin
            rx_wait = draw_wait();
            if (rx_wait > 0) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (rx_wait - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin
        int directed_n;
        int target;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: heat up past max, hold, cool below the band, then every command
        send_item(1'b1, 16'sd0, CMD_NONE, 2'd0);
        send_item(1'b1, TEMP_HI, CMD_ON, 2'd0);
        send_item(1'b1, TEMP_HI, CMD_NONE, 2'd0);
        send_item(1'b1, TEMP_HI, CMD_NONE, 2'd0);
        send_item(1'b1, TEMP_HI, CMD_NONE, 2'd0);
        // device on while above max goes to hold
        send_item(1'b1, TEMP_HI, CMD_ON, 2'd0);
        // sample flag low: value must be ignored
        send_item(1'b0, 16'h8000, CMD_NONE, 2'd0);
        send_item(1'b1, TEMP_LO, CMD_NONE, 2'd0);
        send_item(1'b1, 16'h8000, CMD_NONE, 2'd0);
        send_item(1'b1, TEMP_LO, CMD_NONE, 2'd0);
        send_item(1'b1, TEMP_LO, CMD_NONE, 2'd0);
        // force with every count, zero included
        send_item(1'b0, TEMP_LO, CMD_FORCE, 2'd0);
        send_item(1'b1, 16'sd0, CMD_FORCE, 2'd1);
        send_item(1'b1, 16'sd0, CMD_FORCE, 2'd2);
        send_item(1'b1, 16'h7FFF, CMD_FORCE, 2'd3);
        send_item(1'b1, 16'h7FFF, CMD_ON, 2'd0);
        // stop keeps hold, off clears it
        send_item(1'b1, TEMP_HI, CMD_STOP, 2'd0);
        send_item(1'b1, TEMP_LO, CMD_RSVD5, 2'd3);
        send_item(1'b1, 16'h8000, CMD_RSVD6, 2'd1);
        send_item(1'b1, 16'h8000, CMD_RSVD7, 2'd2);
        send_item(1'b0, 16'hFFFF, CMD_OFF, 2'd0);
        send_item(1'b1, 16'h7FFF, CMD_ON, 2'd3);
        send_item(1'b1, 16'sd0, CMD_NONE, 2'd0);
        directed_n = items_sent;

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       set_config(TEMP_LO, 0);
                1:       set_config(TEMP_HI, 2560);
                2:       set_config(5632, 512);
                default: set_config(int'($urandom_range(0, 42240)) - 10240,
                                    $urandom_range(0, 2560));
            endcase
            no_idle = (phase % 4 == 3);
            target = directed_n + (phase + 1) * RANDOM_ITEMS / PHASES;
            while (items_sent < target) begin
                run_burst();
                if ($urandom_range(0, 11) == 0)
                    drain();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests (%0d directed) under %0d register writes;",
                 items_sent, directed_n, cfg_writes);
        $display("checked %0d results, %0d of them hysteresis switchovers.",
                 result_count, swing_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
